FILE: design/crt_pkg.sv
package crt_pkg;

  localparam int MAX_PARTS_DEF   = 1024;
  localparam int STORE_BYTES_DEF = 65536;
  localparam int MISSING_CAP_DEF = 50;

  localparam logic [15:0] CPB_RESET = 16'd248;
  localparam logic [31:0] TMO_RESET = 32'd120000;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 144;

  // input actions
  localparam logic [1:0] A_HDR  = 2'd0;
  localparam logic [1:0] A_BYTE = 2'd1;
  localparam logic [1:0] A_TICK = 2'd2;
  localparam logic [1:0] A_READ = 2'd3;

  // result kinds
  localparam logic [1:0] K_CHUNK = 2'd0;
  localparam logic [1:0] K_MISS  = 2'd1;
  localparam logic [1:0] K_READ  = 2'd2;
  localparam logic [1:0] K_TMO   = 2'd3;

  // chunk outcomes
  localparam logic [2:0] OC_STORED   = 3'd0;
  localparam logic [2:0] OC_COMPLETE = 3'd1;
  localparam logic [2:0] OC_GAPS     = 3'd2;
  localparam logic [2:0] OC_DUP      = 3'd3;
  localparam logic [2:0] OC_BADPART  = 3'd4;
  localparam logic [2:0] OC_TOOMANY  = 3'd5;
  localparam logic [2:0] OC_OVERFLOW = 3'd6;

  // file types
  localparam logic [1:0] FT_BIN = 2'd0;
  localparam logic [1:0] FT_JPG = 2'd1;
  localparam logic [1:0] FT_PNG = 2'd2;
  localparam logic [1:0] FT_GIF = 2'd3;

  // configuration register indexes
  localparam logic CFG_CPB = 1'b0;
  localparam logic CFG_TMO = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  outcome;
    logic [15:0] bid;
    logic [15:0] miss;
    logic [16:0] alen;
    logic [1:0]  ftype;
    logic [7:0]  rdata;
  } res_t;

  function automatic logic [OUT_TDATA_W-1:0] pack_out(res_t r, logic [15:0] pc,
                                                      logic [31:0] dup, logic [31:0] pkt);
    pack_out = {2'b00, r.rdata, pkt, dup, r.ftype, pc, r.alen, r.miss, r.bid, r.outcome};
  endfunction

  function automatic logic [1:0] file_kind(logic [3:0][7:0] h, logic [16:0] blen);
    logic ge4;
    ge4 = (blen >= 17'd4);
    if (blen < 17'd2) file_kind = FT_BIN;
    else if (h[0] == 8'hFF && h[1] == 8'hD8) file_kind = FT_JPG;
    else if (ge4 && h[0] == 8'h89 && h[1] == 8'h50 && h[2] == 8'h4E && h[3] == 8'h47)
      file_kind = FT_PNG;
    else if (ge4 && h[0] == 8'h47 && h[1] == 8'h49 && h[2] == 8'h46 && h[3] == 8'h38)
      file_kind = FT_GIF;
    else file_kind = FT_BIN;
  endfunction

endpackage

FILE: design/crt_ram.sv
module crt_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                         rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/chunk_reassembly_tracker.sv
// Chunk reassembly tracker: header requests open a chunk of a numbered block,
// payload-byte requests write it into a byte store at (part-1)*chunk_payload_bytes,
// tick requests age the block toward a timeout, read requests return a store byte.
// One request is handled at a time under a small sequencer. A payload byte that ends
// its chunk, and a header with zero length, go on through the finish states; a header
// that opens a new block first sweeps the store and part mask, one entry per cycle,
// over max(STORE_BYTES, MAX_PARTS) entries. The same sweep runs after reset before the
// first request is taken. A final chunk with gaps scans the part mask part by part,
// emitting up to MISSING_CAP entries. Results go through one output register and a
// stalled output holds the sequencer.
module chunk_reassembly_tracker #(
  parameter int MAX_PARTS   = crt_pkg::MAX_PARTS_DEF,
  parameter int STORE_BYTES = crt_pkg::STORE_BYTES_DEF,
  parameter int MISSING_CAP = crt_pkg::MISSING_CAP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // blk id, part no, part total, length, payload byte, read addr
  input  logic [crt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // outcome, result_block_id, missing_part, assembled_length, part_count,
  // file_type, duplicates_seen, packets_seen, read_data
  output logic [crt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // kind
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int SAW     = $clog2(STORE_BYTES);
  localparam int LW      = SAW + 1;
  localparam int MAW     = MAX_PARTS > 1 ? $clog2(MAX_PARTS) : 1;
  localparam int CLR_LEN = STORE_BYTES > MAX_PARTS ? STORE_BYTES : MAX_PARTS;
  localparam int CW      = $clog2(CLR_LEN + 1);
  localparam int FW      = $clog2(MISSING_CAP + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RCLR     = 4'd1;
  localparam logic [3:0] S_HDR      = 4'd2;
  localparam logic [3:0] S_CLR      = 4'd3;
  localparam logic [3:0] S_CHK      = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_HEND     = 4'd6;
  localparam logic [3:0] S_FIN      = 4'd7;
  localparam logic [3:0] S_FIN2     = 4'd8;
  localparam logic [3:0] S_SCAN_RD  = 4'd9;
  localparam logic [3:0] S_SCAN_CHK = 4'd10;
  localparam logic [3:0] S_SCAN_END = 4'd11;
  localparam logic [3:0] S_TICK     = 4'd12;
  localparam logic [3:0] S_RD0      = 4'd13;
  localparam logic [3:0] S_RD       = 4'd14;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] active_r, active_nxt, expected_r, expected_nxt, rcvd_r, rcvd_nxt;
  logic [LW-1:0] blen_r, blen_nxt, wp_r, wp_nxt, coff_r, coff_nxt;
  logic [31:0] idle_r, idle_nxt, dup_r, dup_nxt, pkt_r, pkt_nxt;
  logic [15:0] left_r, left_nxt;
  logic [2:0]  pend_r, pend_nxt, oc_r, oc_nxt;
  logic [15:0] cblk_r, cblk_nxt, cpart_r, cpart_nxt, ctot_r, ctot_nxt, clen_r, clen_nxt;
  logic [15:0] cpb_r, cpb_nxt;
  logic [31:0] tmo_r, tmo_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [FW-1:0] found_r, found_nxt;
  logic [16:0] idx_r, idx_nxt;
  logic [3:0][7:0] head_r, head_nxt;
  logic [15:0] rdaddr_r, rdaddr_nxt;
  logic        oob_r, oob_nxt;
  crt_pkg::res_t hold_r, hold_nxt;
  logic        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [crt_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;

  logic [15:0] in_bid, in_part, in_tot, in_len, in_addr;
  logic [7:0]  in_byte;
  logic        acc, out_free, emit, emit_last;
  crt_pkg::res_t emit_res;

  logic            st_we, mk_we, mk_wdata, mk_q;
  logic [SAW-1:0]  st_waddr, st_raddr;
  logic [7:0]      st_wdata, st_q;
  logic [MAW-1:0]  mk_waddr, mk_raddr;
  logic [15:0]     part_m1;
  logic [32:0]     end_off;

  assign in_bid  = in_tdata[15:0];
  assign in_part = in_tdata[31:16];
  assign in_tot  = in_tdata[47:32];
  assign in_len  = in_tdata[63:48];
  assign in_byte = in_tdata[71:64];
  assign in_addr = in_tdata[87:72];

  assign in_tready  = (state_r == S_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign part_m1    = cpart_r - 16'd1;
  assign end_off    = {1'b0, prod_r} + {17'd0, clen_r};

  crt_ram #(.DW(8), .DEPTH(STORE_BYTES)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_q)
  );

  crt_ram #(.DW(1), .DEPTH(MAX_PARTS)) u_mask (
    .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
    .raddr(mk_raddr), .rdata(mk_q)
  );

  assign st_raddr = SAW'(rdaddr_r);

  always_comb begin
    state_nxt = state_r; active_nxt = active_r; expected_nxt = expected_r;
    rcvd_nxt = rcvd_r; blen_nxt = blen_r; wp_nxt = wp_r; coff_nxt = coff_r;
    idle_nxt = idle_r; dup_nxt = dup_r; pkt_nxt = pkt_r; left_nxt = left_r;
    pend_nxt = pend_r; oc_nxt = oc_r; cblk_nxt = cblk_r; cpart_nxt = cpart_r;
    ctot_nxt = ctot_r; clen_nxt = clen_r; cpb_nxt = cpb_r; tmo_nxt = tmo_r;
    clr_nxt = clr_r; prod_nxt = prod_r; found_nxt = found_r; idx_nxt = idx_r;
    head_nxt = head_r; rdaddr_nxt = rdaddr_r; oob_nxt = oob_r; hold_nxt = hold_r;
    out_valid_nxt = out_valid_r; out_last_nxt = out_last_r;
    out_data_nxt = out_data_r; out_kind_nxt = out_kind_r;
    emit = 1'b0; emit_last = 1'b1; emit_res = '0;
    st_we = 1'b0; st_waddr = wp_r[SAW-1:0]; st_wdata = in_byte;
    mk_we = 1'b0; mk_waddr = part_m1[MAW-1:0]; mk_wdata = 1'b1;
    mk_raddr = idx_r[MAW-1:0];

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    if (cfg_we) begin
      if (cfg_index == crt_pkg::CFG_CPB) cpb_nxt = cfg_data[15:0];
      else tmo_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_tuser)
            crt_pkg::A_HDR: begin
              if (pkt_r != '1) pkt_nxt = pkt_r + 32'd1;
              left_nxt = '0;
              cblk_nxt = in_bid; cpart_nxt = in_part; ctot_nxt = in_tot;
              clen_nxt = in_len; coff_nxt = '0;
              state_nxt = S_HDR;
            end
            crt_pkg::A_BYTE: begin
              if (left_r != '0) begin
                if (pend_r == crt_pkg::OC_STORED && wp_r < LW'(STORE_BYTES)) begin
                  st_we  = 1'b1;
                  wp_nxt = wp_r + LW'(1);
                  if (wp_r < LW'(4)) head_nxt[wp_r[1:0]] = in_byte;
                end
                left_nxt = left_r - 16'd1;
                if (left_r == 16'd1) state_nxt = S_FIN;
              end
            end
            crt_pkg::A_TICK: begin
              if (active_r != '0) begin
                if (idle_r != '1) idle_nxt = idle_r + 32'd1;
                state_nxt = S_TICK;
              end
            end
            default: begin
              rdaddr_nxt = in_addr;
              oob_nxt    = {1'b0, in_addr} >= 17'(STORE_BYTES);
              state_nxt  = S_RD0;
            end
          endcase
        end
      end
      S_RCLR, S_CLR: begin
        if (clr_r < CW'(STORE_BYTES)) begin
          st_we = 1'b1; st_waddr = clr_r[SAW-1:0]; st_wdata = 8'd0;
        end
        if (clr_r < CW'(MAX_PARTS)) begin
          mk_we = 1'b1; mk_waddr = clr_r[MAW-1:0]; mk_wdata = 1'b0;
        end
        head_nxt = '0;
        clr_nxt  = clr_r + CW'(1);
        if (clr_r == CW'(CLR_LEN - 1)) state_nxt = (state_r == S_CLR) ? S_CHK : S_IDLE;
      end
      S_HDR: begin
        if (active_r != cblk_r) begin
          if ({1'b0, ctot_r} > 17'(MAX_PARTS)) begin
            oc_nxt = crt_pkg::OC_TOOMANY; state_nxt = S_HEND;
          end else begin
            active_nxt = cblk_r; expected_nxt = ctot_r; rcvd_nxt = '0;
            blen_nxt = '0; idle_nxt = '0; clr_nxt = '0;
            state_nxt = S_CLR;
          end
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (cpart_r == '0 || cpart_r > ctot_r || {1'b0, cpart_r} > 17'(MAX_PARTS)) begin
          oc_nxt = crt_pkg::OC_BADPART; state_nxt = S_HEND;
        end else begin
          mk_raddr  = part_m1[MAW-1:0];
          prod_nxt  = part_m1 * cpb_r;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mk_q) begin
          if (dup_r != '1) dup_nxt = dup_r + 32'd1;
          oc_nxt = crt_pkg::OC_DUP;
        end else if (end_off > 33'(STORE_BYTES)) begin
          oc_nxt = crt_pkg::OC_OVERFLOW;
        end else begin
          oc_nxt = crt_pkg::OC_STORED;
          coff_nxt = LW'(prod_r); wp_nxt = LW'(prod_r);
        end
        state_nxt = S_HEND;
      end
      S_HEND: begin
        pend_nxt  = oc_r;
        left_nxt  = clen_r;
        state_nxt = (clen_r == '0) ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (pend_r != crt_pkg::OC_STORED) begin
          if (out_free) begin
            emit = 1'b1; emit_res.kind = crt_pkg::K_CHUNK;
            emit_res.outcome = pend_r; emit_res.bid = cblk_r;
            state_nxt = S_IDLE;
          end
        end else begin
          mk_we = 1'b1;
          rcvd_nxt = rcvd_r + 16'd1;
          idle_nxt = '0;
          if (cpart_r == ctot_r) blen_nxt = coff_r + LW'(clen_r);
          state_nxt = S_FIN2;
        end
      end
      S_FIN2: begin
        if (rcvd_r == expected_r) begin
          if (out_free) begin
            emit = 1'b1; emit_res.kind = crt_pkg::K_CHUNK;
            emit_res.outcome = crt_pkg::OC_COMPLETE; emit_res.bid = cblk_r;
            emit_res.alen = 17'(blen_r);
            emit_res.ftype = crt_pkg::file_kind(head_r, 17'(blen_r));
            active_nxt = '0;
            state_nxt = S_IDLE;
          end
        end else if (cpart_r == ctot_r && rcvd_r < expected_r) begin
          hold_nxt = '0;
          hold_nxt.kind = crt_pkg::K_CHUNK; hold_nxt.outcome = crt_pkg::OC_GAPS;
          hold_nxt.bid = cblk_r; hold_nxt.alen = 17'(blen_r);
          idx_nxt = '0; found_nxt = '0;
          state_nxt = S_SCAN_RD;
        end else if (out_free) begin
          emit = 1'b1; emit_res.kind = crt_pkg::K_CHUNK;
          emit_res.outcome = crt_pkg::OC_STORED; emit_res.bid = cblk_r;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (idx_r < {1'b0, ctot_r} && idx_r < 17'(MAX_PARTS) &&
            found_r < FW'(MISSING_CAP)) begin
          state_nxt = S_SCAN_CHK;
        end else begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_CHK: begin
        if (mk_q) begin
          idx_nxt = idx_r + 17'd1; state_nxt = S_SCAN_RD;
        end else if (out_free) begin
          // the held result goes out only once a later one is known to follow
          emit = 1'b1; emit_last = 1'b0; emit_res = hold_r;
          hold_nxt = '0;
          hold_nxt.kind = crt_pkg::K_MISS; hold_nxt.bid = cblk_r;
          hold_nxt.miss = idx_r[15:0] + 16'd1;
          found_nxt = found_r + FW'(1);
          idx_nxt = idx_r + 17'd1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (out_free) begin
          emit = 1'b1; emit_res = hold_r; state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (idle_r > tmo_r) begin
          if (out_free) begin
            emit = 1'b1; emit_res.kind = crt_pkg::K_TMO; emit_res.bid = active_r;
            active_nxt = '0; left_nxt = '0;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD0: state_nxt = S_RD;
      S_RD: begin
        if (out_free) begin
          emit = 1'b1; emit_res.kind = crt_pkg::K_READ; emit_res.bid = active_r;
          emit_res.rdata = oob_r ? 8'd0 : st_q;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = emit_last;
      out_kind_nxt  = emit_res.kind;
      out_data_nxt  = crt_pkg::pack_out(emit_res, expected_r, dup_r, pkt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RCLR; active_r <= '0; expected_r <= '0; rcvd_r <= '0;
      blen_r <= '0; wp_r <= '0; coff_r <= '0; idle_r <= '0; dup_r <= '0;
      pkt_r <= '0; left_r <= '0; pend_r <= '0; oc_r <= '0; cblk_r <= '0;
      cpart_r <= '0; ctot_r <= '0; clen_r <= '0;
      cpb_r <= crt_pkg::CPB_RESET; tmo_r <= crt_pkg::TMO_RESET;
      clr_r <= '0; found_r <= '0; idx_r <= '0; head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; active_r <= active_nxt; expected_r <= expected_nxt;
      rcvd_r <= rcvd_nxt; blen_r <= blen_nxt; wp_r <= wp_nxt; coff_r <= coff_nxt;
      idle_r <= idle_nxt; dup_r <= dup_nxt; pkt_r <= pkt_nxt; left_r <= left_nxt;
      pend_r <= pend_nxt; oc_r <= oc_nxt; cblk_r <= cblk_nxt; cpart_r <= cpart_nxt;
      ctot_r <= ctot_nxt; clen_r <= clen_nxt; cpb_r <= cpb_nxt; tmo_r <= tmo_nxt;
      clr_r <= clr_nxt; found_r <= found_nxt; idx_r <= idx_nxt; head_r <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt; rdaddr_r <= rdaddr_nxt; oob_r <= oob_nxt; hold_r <= hold_nxt;
    out_last_r <= out_last_nxt; out_data_r <= out_data_nxt; out_kind_r <= out_kind_nxt;
  end

`ifndef SYNTHESIS
  a_found_cap: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= FW'(MISSING_CAP))
    else $error("missing-part count above cap");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= LW'(STORE_BYTES))
    else $error("write pointer beyond store");

  a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR || state_r == S_RCLR) |-> !in_tready)
    else $error("request taken during store clear");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("pending result dropped");
`endif

endmodule

FILE: tb/chunk_reassembly_tracker_tb.sv
`timescale 1ns / 100ps

module chunk_reassembly_tracker_tb;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] bid;
    logic [15:0] part;
    logic [15:0] tp;
    logic [15:0] len;
    logic [7:0]  dbyte;
    logic [15:0] addr;
  } req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  oc;
    logic [15:0] bid;
    logic [15:0] miss;
    logic [16:0] alen;
    logic [15:0] pc;
    logic [1:0]  ft;
    logic [31:0] dup;
    logic [31:0] pkt;
    logic [7:0]  rd;
    logic        last;
  } chunk_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [crt_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = crt_pkg::A_READ;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [crt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = crt_pkg::CFG_CPB;
  logic [31:0] cfg_data = '0;

  chunk_reassembly_tracker uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t       pending_reqs[$];
  chunk_res_t expected_results[$];
  req_t       cur_req;
  int         errors = 0;
  int         n_reqs = 0;
  int         n_acc = 0;
  int         n_res = 0;

  // shadow of the tracker
  logic [15:0] cpb = crt_pkg::CPB_RESET;
  logic [31:0] tmo = crt_pkg::TMO_RESET;
  logic [15:0] active_bid, exp_parts, rcvd, bytes_left, c_bid, c_part, c_total, c_len;
  logic [16:0] blen, wptr, c_off;
  logic [31:0] idle_ms, dup_total, pkt_total;
  logic [2:0]  pend_oc;
  logic [7:0]  store [0:crt_pkg::STORE_BYTES_DEF-1];
  logic        seen [0:crt_pkg::MAX_PARTS_DEF-1];

  task automatic clear_block_store();
    foreach (store[i]) store[i] = 8'h00;
    foreach (seen[i]) seen[i] = 1'b0;
  endtask

  task automatic add_result(logic [1:0] kind, logic [2:0] oc, logic [15:0] bid,
                            logic [15:0] miss, logic [16:0] alen, logic [1:0] ft,
                            logic [7:0] rd);
    chunk_res_t r;
    r = '{kind, oc, bid, miss, alen, exp_parts, ft, dup_total, pkt_total, rd, 1'b0};
    expected_results.push_back(r);
  endtask

  function automatic logic [1:0] magic_type();
    if (blen < 2) return crt_pkg::FT_BIN;
    if (store[0] == 8'hFF && store[1] == 8'hD8) return crt_pkg::FT_JPG;
    if (blen >= 4 && store[0] == 8'h89 && store[1] == 8'h50 && store[2] == 8'h4E &&
        store[3] == 8'h47) return crt_pkg::FT_PNG;
    if (blen >= 4 && store[0] == 8'h47 && store[1] == 8'h49 && store[2] == 8'h46 &&
        store[3] == 8'h38) return crt_pkg::FT_GIF;
    return crt_pkg::FT_BIN;
  endfunction

  task automatic close_chunk();
    int  n;
    bit  gaps;
    n = 0;
    gaps = 0;
    if (pend_oc != crt_pkg::OC_STORED) begin
      add_result(crt_pkg::K_CHUNK, pend_oc, c_bid, 0, 0, crt_pkg::FT_BIN, 0);
    end else begin
      seen[c_part - 1] = 1'b1;
      rcvd++;
      idle_ms = 0;
      if (c_part == c_total) begin
        blen = c_off + c_len;
        if (rcvd < exp_parts) gaps = 1;
      end
      if (rcvd == exp_parts) begin
        add_result(crt_pkg::K_CHUNK, crt_pkg::OC_COMPLETE, c_bid, 0, blen, magic_type(), 0);
        active_bid = 0;
      end else if (gaps) begin
        add_result(crt_pkg::K_CHUNK, crt_pkg::OC_GAPS, c_bid, 0, blen, crt_pkg::FT_BIN, 0);
        for (int i = 0; i < c_total && i < crt_pkg::MAX_PARTS_DEF &&
             n < crt_pkg::MISSING_CAP_DEF; i++)
          if (!seen[i]) begin
            add_result(crt_pkg::K_MISS, crt_pkg::OC_STORED, c_bid, 16'(i + 1), 0,
                       crt_pkg::FT_BIN, 0);
            n++;
          end
      end else begin
        add_result(crt_pkg::K_CHUNK, crt_pkg::OC_STORED, c_bid, 0, 0, crt_pkg::FT_BIN, 0);
      end
    end
    expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  task automatic track_request(req_t q);
    longint off;
    case (q.action)
      crt_pkg::A_HDR: begin
        if (pkt_total != '1) pkt_total++;
        c_bid = q.bid;
        c_part = q.part;
        c_total = q.tp;
        c_len = q.len;
        c_off = 0;
        pend_oc = crt_pkg::OC_STORED;
        if (active_bid != q.bid) begin
          if (q.tp > crt_pkg::MAX_PARTS_DEF) begin
            pend_oc = crt_pkg::OC_TOOMANY;
          end else begin
            active_bid = q.bid;
            exp_parts = q.tp;
            rcvd = 0;
            blen = 0;
            idle_ms = 0;
            clear_block_store();
          end
        end
        if (pend_oc == crt_pkg::OC_STORED) begin
          if (q.part == 0 || q.part > q.tp || q.part > crt_pkg::MAX_PARTS_DEF) begin
            pend_oc = crt_pkg::OC_BADPART;
          end else if (seen[q.part - 1]) begin
            if (dup_total != '1) dup_total++;
            pend_oc = crt_pkg::OC_DUP;
          end else begin
            off = longint'(q.part - 1) * longint'(cpb);
            if (off + q.len > crt_pkg::STORE_BYTES_DEF) begin
              pend_oc = crt_pkg::OC_OVERFLOW;
            end else begin
              c_off = off[16:0];
              wptr = off[16:0];
            end
          end
        end
        bytes_left = q.len;
        if (q.len == 0) close_chunk();
      end
      crt_pkg::A_BYTE: begin
        if (bytes_left != 0) begin
          if (pend_oc == crt_pkg::OC_STORED && wptr < crt_pkg::STORE_BYTES_DEF) begin
            store[wptr[15:0]] = q.dbyte;
            wptr++;
          end
          bytes_left--;
          if (bytes_left == 0) close_chunk();
        end
      end
      crt_pkg::A_TICK: begin
        if (active_bid != 0) begin
          if (idle_ms != '1) idle_ms++;
          if (idle_ms > tmo) begin
            add_result(crt_pkg::K_TMO, crt_pkg::OC_STORED, active_bid, 0, 0,
                       crt_pkg::FT_BIN, 0);
            expected_results[expected_results.size() - 1].last = 1'b1;
            active_bid = 0;
            bytes_left = 0;
          end
        end
      end
      default: begin
        add_result(crt_pkg::K_READ, crt_pkg::OC_STORED, active_bid, 0, 0,
                   crt_pkg::FT_BIN, store[q.addr]);
        expected_results[expected_results.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  // request driver; a no-idle stretch covers requests 60..109
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_request(cur_req);
        n_acc++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 &&
            ((n_acc >= 60 && n_acc < 110) || $urandom_range(99) >= 17)) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.action;
          in_tdata <= {cur_req.addr, cur_req.dbyte, cur_req.len, cur_req.tp,
                       cur_req.part, cur_req.bid};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", n_res, what, got, want);
    errors++;
  endtask

  // result monitor
  always @(posedge clk) begin
    chunk_res_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, kind", 64'(out_tuser), 64'(0));
        end else begin
          e = expected_results.pop_front();
          if (out_tuser != e.kind)
            report_mismatch("kind", 64'(out_tuser), 64'(e.kind));
          if (out_tdata[2:0] != e.oc)
            report_mismatch("outcome", 64'(out_tdata[2:0]), 64'(e.oc));
          if (out_tdata[18:3] != e.bid)
            report_mismatch("block id", 64'(out_tdata[18:3]), 64'(e.bid));
          if (out_tdata[34:19] != e.miss)
            report_mismatch("missing", 64'(out_tdata[34:19]), 64'(e.miss));
          if (out_tdata[51:35] != e.alen)
            report_mismatch("length", 64'(out_tdata[51:35]), 64'(e.alen));
          if (out_tdata[67:52] != e.pc)
            report_mismatch("part count", 64'(out_tdata[67:52]), 64'(e.pc));
          if (out_tdata[69:68] != e.ft)
            report_mismatch("file type", 64'(out_tdata[69:68]), 64'(e.ft));
          if (out_tdata[101:70] != e.dup)
            report_mismatch("dups", 64'(out_tdata[101:70]), 64'(e.dup));
          if (out_tdata[133:102] != e.pkt)
            report_mismatch("pkts", 64'(out_tdata[133:102]), 64'(e.pkt));
          if (out_tdata[141:134] != e.rd)
            report_mismatch("read", 64'(out_tdata[141:134]), 64'(e.rd));
          if (out_tlast != e.last)
            report_mismatch("last", 64'(out_tlast), 64'(e.last));
        end
        n_res++;
      end
      out_tready <= (n_res >= 30 && n_res < 70) || $urandom_range(99) >= 17;
    end
  end

  task automatic push_req(logic [1:0] a, logic [15:0] bid, logic [15:0] part,
                          logic [15:0] tp, logic [15:0] len, logic [7:0] b,
                          logic [15:0] addr);
    req_t q;
    q = '{a, bid, part, tp, len, b, addr};
    pending_reqs.push_back(q);
    n_reqs++;
  endtask

  task automatic push_hdr(logic [15:0] bid, logic [15:0] part, logic [15:0] tp,
                          logic [15:0] len);
    push_req(crt_pkg::A_HDR, bid, part, tp, len, 8'($urandom), 16'($urandom));
  endtask

  task automatic push_byte(logic [7:0] b);
    push_req(crt_pkg::A_BYTE, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), b, 16'($urandom));
  endtask

  task automatic push_tick();
    push_req(crt_pkg::A_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic push_read(logic [15:0] addr);
    push_req(crt_pkg::A_READ, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 8'($urandom), addr);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == crt_pkg::CFG_CPB) cpb = val[15:0];
    else tmo = val;
  endtask

  // every phase ends on a read, so an empty expectation queue means idle
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  // one block of random chunks, shuffled, with noise between headers
  task automatic random_block(logic [15:0] bid);
    int tp, len, j, tmp, magic;
    int ord[10];
    logic [7:0] pay;
    tp = $urandom_range(1, 10);
    magic = $urandom_range(3);
    for (int i = 0; i < tp; i++) ord[i] = i + 1;
    for (int i = tp - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = ord[i];
      ord[i] = ord[j];
      ord[j] = tmp;
    end
    for (int i = 0; i < tp; i++) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(5))
          0: push_tick();
          1: push_read(16'($urandom));
          2: push_byte(8'($urandom));
          3: push_hdr(bid, 16'(ord[0]), 16'(tp), 16'd0);
          4: push_hdr(bid, 16'($urandom), 16'($urandom), 16'd0);
          default: push_hdr(16'($urandom), 16'($urandom),
                            16'($urandom_range(1025, 65535)), 16'($urandom));
        endcase
      end
      len = (ord[i] == tp) ? $urandom_range(0, cpb) : cpb;
      if ($urandom_range(99) < 10 && len > 1) begin
        // truncated chunk, sent again in full below
        push_hdr(bid, 16'(ord[i]), 16'(tp), 16'(len));
        push_byte(8'($urandom));
      end
      push_hdr(bid, 16'(ord[i]), 16'(tp), 16'(len));
      for (int k = 0; k < len; k++) begin
        pay = 8'($urandom);
        if (ord[i] == 1 && k < 4) begin
          case (magic)
            1: pay = (k == 0) ? 8'hFF : (k == 1) ? 8'hD8 : pay;
            2: pay = (k == 0) ? 8'h89 : (k == 1) ? 8'h50 : (k == 2) ? 8'h4E : 8'h47;
            3: pay = (k == 0) ? 8'h47 : (k == 1) ? 8'h49 : (k == 2) ? 8'h46 : 8'h38;
            default: ;
          endcase
        end
        push_byte(pay);
      end
    end
    push_read(16'($urandom_range(0, 63)));
  endtask

  initial begin
    logic [15:0] bid;
    int nblk;
    active_bid = 0; exp_parts = 0; rcvd = 0; bytes_left = 0; blen = 0; wptr = 0;
    c_bid = 0; c_part = 0; c_total = 0; c_len = 0; c_off = 0;
    idle_ms = 0; dup_total = 0; pkt_total = 0; pend_oc = crt_pkg::OC_STORED;
    clear_block_store();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(crt_pkg::CFG_CPB, 4);
    write_reg(crt_pkg::CFG_TMO, 3);
    push_read(16'hFFFF);
    push_byte(8'hFF);
    push_tick();
    push_hdr(0, 1, 2, 0);             // block id zero while idle
    push_hdr(7, 1, 3, 4);
    push_byte(8'hFF); push_byte(8'hD8); push_byte(8'h00); push_byte(8'hFF);
    push_hdr(7, 1, 3, 1); push_byte(8'h00);            // duplicate
    push_hdr(7, 0, 3, 0);                              // part zero
    push_hdr(7, 4, 3, 0);                              // part above total
    push_hdr(9, 1, 2000, 2); push_byte(8'h55); push_byte(8'hAA);
    push_hdr(7, 3, 3, 2); push_byte(8'h12); push_byte(8'h34);
    push_hdr(7, 2, 3, 3); push_byte(8'h77);            // dropped by next header
    push_hdr(7, 2, 3, 4);
    push_byte(8'h01); push_byte(8'h02); push_byte(8'h03); push_byte(8'h04);
    push_read(0); push_read(9);
    push_hdr(5, 1, 2, 0);
    repeat (4) push_tick();                            // times out
    push_byte(8'h99);
    push_read(1);
    drain();

    write_reg(crt_pkg::CFG_CPB, 32'h0000_FFFF);
    write_reg(crt_pkg::CFG_TMO, 32'hFFFF_FFFF);
    push_hdr(11, 2, 2, 2);                             // past the store end
    push_byte(8'hAB); push_byte(8'hCD);
    push_hdr(11, 2, 2, 1); push_byte(8'hEE);
    push_hdr(11, 1, 2, 0);
    push_read(16'hFFFF);
    drain();

    write_reg(crt_pkg::CFG_CPB, 1);
    push_hdr(20, 1024, 1024, 0);                       // missing list capped
    push_hdr(20, 1025, 1025, 0);
    push_tick();
    push_read(0);
    drain();

    write_reg(crt_pkg::CFG_TMO, 40);
    nblk = 0;
    while (n_reqs < 230 && nblk < 6) begin
      write_reg(crt_pkg::CFG_CPB, $urandom_range(4, 8));
      bid = 16'($urandom_range(1, 65535));
      random_block(bid);
      nblk++;
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
